FILE: sv/ccg_pkg.sv
// Shared types, widths and codes of the chroma color generator.
`default_nettype none
package ccg_pkg;

	localparam int COLOR_W = 24;
	localparam int PHASE_W = 16;
	localparam int PCT_W = 14;
	localparam int PROG_W = 7;
	localparam int KIDX_W = 3;
	localparam int KPOS_W = 9;
	localparam int REQ_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int CNT_W = 4;

	localparam int HUE_FULL = 5760;
	localparam int HUE_SECTOR = 960;
	localparam int HUE_POS_MAX = 359;
	localparam int PROG_POS_MAX = 127;
	localparam int SAT_MAX = 100;

	localparam int FRAC_W = 16;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES = FRAC_W / DIV_PER_STAGE;

	// Reciprocal of 375 for the rainbow channel scaling.
	localparam int RECIP_375 = 89479;
	localparam int RECIP_SHIFT = 25;

	localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_HUE_KEY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PROG_KEY = 2'd2;

	localparam logic [2:0] MODE_STATIC = 3'd1;
	localparam logic [2:0] MODE_RAINBOW = 3'd2;
	localparam logic [2:0] MODE_HUE_GRAD = 3'd3;
	localparam logic [2:0] MODE_PROG_GRAD = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STATIC_COLOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_BEST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GRADIENT_COUNT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRESS_COUNT = 3'd6;

	typedef enum logic [1:0] {
		OP_FIXED,
		OP_RAINBOW,
		OP_HUE,
		OP_PROG
	} op_t;

endpackage
`default_nettype wire

FILE: sv/ccg_if.sv
// Request and response channel interfaces of the chroma color generator.
`default_nettype none
interface ccg_req_if;
	logic valid;
	logic ready;
	logic [ccg_pkg::REQ_W-1:0] req_type;
	logic [ccg_pkg::COLOR_W-1:0] default_color;
	logic [ccg_pkg::PHASE_W-1:0] phase;
	logic [ccg_pkg::PCT_W-1:0] percentage;
	logic [ccg_pkg::PROG_W-1:0] progress;
	logic [ccg_pkg::KIDX_W-1:0] key_index;
	logic [ccg_pkg::KPOS_W-1:0] key_position;
	logic [ccg_pkg::COLOR_W-1:0] key_color;

	modport source (output valid, req_type, default_color, phase, percentage, progress,
		key_index, key_position, key_color, input ready);
	modport sink (input valid, req_type, default_color, phase, percentage, progress,
		key_index, key_position, key_color, output ready);
endinterface

interface ccg_rsp_if;
	logic valid;
	logic ready;
	logic [ccg_pkg::COLOR_W-1:0] color;
	logic write_ack;

	modport source (output valid, color, write_ack, input ready);
	modport sink (input valid, color, write_ack, output ready);
endinterface
`default_nettype wire

FILE: sv/chroma_color_generator.sv
// Chroma color generator: static, rainbow and keypoint gradient colors per request.
//
// Requests arrive on the req channel and each gives exactly one item on the rsp
// channel, in order. A compute request returns a packed RGB color; a keypoint
// write updates a table entry and returns color zero with write_ack set.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while no request is in flight, as the block does not enforce it.
// The block is a 13-stage pipeline; one request can be accepted every cycle while
// the receiver does not stall. The depth is set by the 16-bit interpolation
// divider, which resolves two quotient bits per stage.
// Keypoint writes take effect as they leave the first stage, so later compute
// requests always see them.
// Reset clears the configuration to its defaults and empties the pipeline; the
// keypoint tables are not cleared and must be written before they are used.
// When the receiver stalls, the whole pipeline holds and req.ready drops.
`default_nettype none
module chroma_color_generator #(
	parameter int MAX_KEYS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	ccg_req_if.sink req,
	ccg_rsp_if.source rsp,
	input wire logic cfg_we,
	input wire logic [ccg_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [ccg_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NW = $clog2(MAX_KEYS + 1);
	localparam int NDS = ccg_pkg::DIV_STAGES;
	localparam int CW = ccg_pkg::COLOR_W;
	localparam int FW = ccg_pkg::FRAC_W;

	logic adv;

	logic enable_q, use_best_q;
	logic [2:0] mode_q;
	logic [CW-1:0] static_color_q;
	logic [6:0] saturation_q;
	logic [ccg_pkg::CNT_W-1:0] gradient_count_q, progress_count_q;

	logic [8:0] hpos_q [MAX_KEYS];
	logic [CW-1:0] hcol_q [MAX_KEYS];
	logic [6:0] ppos_q [MAX_KEYS];
	logic [CW-1:0] pcol_q [MAX_KEYS];

	logic v_s1, ack_s1, wr_hue_s1, wr_prog_s1;
	ccg_pkg::op_t op_s1;
	logic [CW-1:0] res_s1, kcol_s1;
	logic [12:0] h_s1;
	logic [13:0] pm_s1;
	logic [2:0] kidx_s1;
	logic [8:0] kpos_s1;

	logic v_s2, ack_s2, blend_s2, rb_s2;
	logic [CW-1:0] res_s2, lc_s2, rc_s2;
	logic signed [15:0] l_s2, r_s2, mid_s2;
	logic [2:0] sec_s2;
	logic [16:0] amd_s2, alo_s2;

	logic v_s3, ack_s3, blend_s3, rb_s3;
	logic [CW-1:0] res_s3, lc_s3, rc_s3;
	logic [13:0] num_s3, den_s3;
	logic [2:0] sec_s3;
	logic [16:0] ymd_s3, ylo_s3;

	// Divider stages: entry j of each array is pipeline stage 4 + j.
	logic v_s4 [NDS];
	logic ack_s4 [NDS];
	logic blend_s4 [NDS];
	logic [CW-1:0] res_s4 [NDS];
	logic [CW-1:0] lc_s4 [NDS];
	logic [CW-1:0] rc_s4 [NDS];
	logic [13:0] rem_s4 [NDS];
	logic [13:0] den_s4 [NDS];
	logic [FW-1:0] q_s4 [NDS];

	logic v_s12, ack_s12, blend_s12;
	logic [CW-1:0] res_s12;
	logic [24:0] pl_s12 [3];
	logic [23:0] pr_s12 [3];

	logic v_s13, ack_s13;
	logic [CW-1:0] color_s13;

	logic [NW-1:0] nh, np;
	logic [6:0] sat;

	assign adv = !v_s13 || rsp.ready;
	assign req.ready = adv;
	assign rsp.valid = v_s13;
	assign rsp.color = color_s13;
	assign rsp.write_ack = ack_s13;

	always_comb begin
		nh = (32'(gradient_count_q) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(gradient_count_q);
		np = (32'(progress_count_q) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(progress_count_q);
		sat = (saturation_q > 7'(ccg_pkg::SAT_MAX)) ? 7'(ccg_pkg::SAT_MAX) : saturation_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			mode_q <= 3'd0;
			static_color_q <= 24'hFFFFFF;
			saturation_q <= 7'(ccg_pkg::SAT_MAX);
			use_best_q <= 1'b0;
			gradient_count_q <= '0;
			progress_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ccg_pkg::CFG_ENABLE: enable_q <= cfg_data[0];
				ccg_pkg::CFG_MODE: mode_q <= cfg_data[2:0];
				ccg_pkg::CFG_STATIC_COLOR: static_color_q <= cfg_data[CW-1:0];
				ccg_pkg::CFG_SATURATION: saturation_q <= cfg_data[6:0];
				ccg_pkg::CFG_USE_BEST: use_best_q <= cfg_data[0];
				ccg_pkg::CFG_GRADIENT_COUNT: gradient_count_q <= cfg_data[3:0];
				ccg_pkg::CFG_PROGRESS_COUNT: progress_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Stage 1: decode the request and reduce the phase into one turn.
	logic [16:0] hx;
	ccg_pkg::op_t op_d;
	logic [CW-1:0] res_d;

	always_comb begin
		hx = 17'(req.phase);
		for (int k = 3; k >= 0; k--) begin
			if (hx >= (17'(ccg_pkg::HUE_FULL) << k)) begin
				hx = hx - (17'(ccg_pkg::HUE_FULL) << k);
			end
		end
		op_d = ccg_pkg::OP_FIXED;
		res_d = '0;
		if (req.req_type == ccg_pkg::REQ_COMPUTE) begin
			res_d = req.default_color;
			if (enable_q) begin
				case (mode_q)
					ccg_pkg::MODE_STATIC: res_d = static_color_q;
					ccg_pkg::MODE_RAINBOW: op_d = ccg_pkg::OP_RAINBOW;
					ccg_pkg::MODE_HUE_GRAD: begin
						if (gradient_count_q != '0) op_d = ccg_pkg::OP_HUE;
					end
					ccg_pkg::MODE_PROG_GRAD: begin
						if (progress_count_q != '0) op_d = ccg_pkg::OP_PROG;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= op_d;
			res_s1 <= res_d;
			ack_s1 <= (req.req_type == ccg_pkg::REQ_HUE_KEY) ||
				(req.req_type == ccg_pkg::REQ_PROG_KEY);
			wr_hue_s1 <= (req.req_type == ccg_pkg::REQ_HUE_KEY) &&
				(32'(req.key_index) < MAX_KEYS);
			wr_prog_s1 <= (req.req_type == ccg_pkg::REQ_PROG_KEY) &&
				(32'(req.key_index) < MAX_KEYS);
			h_s1 <= hx[12:0];
			pm_s1 <= use_best_q ? {req.progress, 7'd0} : req.percentage;
			kidx_s1 <= req.key_index;
			kpos_s1 <= req.key_position;
			kcol_s1 <= req.key_color;
		end
	end

	// Keypoint tables are written as the write item leaves stage 1.
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_KEYS; i++) begin
			if (adv && v_s1 && wr_hue_s1 && (32'(kidx_s1) == i)) begin
				hpos_q[i] <= (kpos_s1 > 9'(ccg_pkg::HUE_POS_MAX)) ?
					9'(ccg_pkg::HUE_POS_MAX) : kpos_s1;
				hcol_q[i] <= kcol_s1;
			end
			if (adv && v_s1 && wr_prog_s1 && (32'(kidx_s1) == i)) begin
				ppos_q[i] <= (kpos_s1 > 9'(ccg_pkg::PROG_POS_MAX)) ?
					7'(ccg_pkg::PROG_POS_MAX) : kpos_s1[6:0];
				pcol_q[i] <= kcol_s1;
			end
		end
	end

	// Stage 2: find the bracketing keys and start the rainbow channels.
	logic is_hue, seen, first0;
	logic [NW-1:0] nsel;
	logic [13:0] mid14, kp_i, sel_p, prv_p, last_p, k0_p, pk;
	logic [CW-1:0] kc_i, sel_c, prv_c, last_c, c0_c, pc;
	logic [2:0] sec_d;
	logic [12:0] base;
	logic [9:0] f_d, t_d;
	logic signed [15:0] l_d, r_d;
	logic [CW-1:0] lc_d, rc_d, res2_d;
	logic blend_d;

	always_comb begin
		is_hue = (op_s1 == ccg_pkg::OP_HUE);
		nsel = is_hue ? nh : np;
		mid14 = is_hue ? {1'b0, h_s1} : pm_s1;
		seen = 1'b0;
		first0 = 1'b0;
		sel_p = '0;
		sel_c = '0;
		prv_p = '0;
		prv_c = '0;
		last_p = '0;
		last_c = '0;
		pk = '0;
		pc = '0;
		k0_p = is_hue ? {1'b0, hpos_q[0], 4'd0} : {ppos_q[0], 7'd0};
		c0_c = is_hue ? hcol_q[0] : pcol_q[0];
		for (int i = 0; i < MAX_KEYS; i++) begin
			kp_i = is_hue ? {1'b0, hpos_q[i], 4'd0} : {ppos_q[i], 7'd0};
			kc_i = is_hue ? hcol_q[i] : pcol_q[i];
			if ((NW'(i) < nsel) && (kp_i > mid14) && !seen) begin
				seen = 1'b1;
				first0 = (i == 0);
				sel_p = kp_i;
				sel_c = kc_i;
				prv_p = pk;
				prv_c = pc;
			end
			if (NW'(i) == nsel - NW'(1)) begin
				last_p = kp_i;
				last_c = kc_i;
			end
			pk = kp_i;
			pc = kc_i;
		end

		blend_d = 1'b0;
		res2_d = res_s1;
		l_d = $signed({2'b0, prv_p});
		r_d = $signed({2'b0, sel_p});
		lc_d = prv_c;
		rc_d = sel_c;
		if (op_s1 == ccg_pkg::OP_HUE) begin
			blend_d = 1'b1;
			if (seen && first0) begin
				l_d = $signed({2'b0, last_p}) - 16'sd5760;
				lc_d = last_c;
			end else if (!seen) begin
				l_d = $signed({2'b0, last_p});
				lc_d = last_c;
				r_d = $signed({2'b0, k0_p}) + 16'sd5760;
				rc_d = c0_c;
			end
		end else if (op_s1 == ccg_pkg::OP_PROG) begin
			if (seen && !first0) begin
				blend_d = 1'b1;
			end else if (seen) begin
				res2_d = c0_c;
			end else begin
				res2_d = last_c;
			end
		end

		sec_d = 3'd0;
		base = '0;
		for (int k = 1; k < 6; k++) begin
			if (h_s1 >= 13'(k * ccg_pkg::HUE_SECTOR)) begin
				sec_d = 3'(k);
				base = 13'(k * ccg_pkg::HUE_SECTOR);
			end
		end
		f_d = 10'(h_s1 - base);
		t_d = sec_d[0] ? (10'(ccg_pkg::HUE_SECTOR) - f_d) : f_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ack_s2 <= ack_s1;
			blend_s2 <= blend_d;
			rb_s2 <= (op_s1 == ccg_pkg::OP_RAINBOW);
			res_s2 <= res2_d;
			l_s2 <= l_d;
			r_s2 <= r_d;
			lc_s2 <= lc_d;
			rc_s2 <= rc_d;
			mid_s2 <= $signed({2'b0, mid14});
			sec_s2 <= sec_d;
			alo_s2 <= 17'(7'(7'(ccg_pkg::SAT_MAX) - sat)) * 17'(ccg_pkg::HUE_SECTOR);
			amd_s2 <= 17'(7'(7'(ccg_pkg::SAT_MAX) - sat)) * 17'(ccg_pkg::HUE_SECTOR) +
				17'(sat) * 17'(t_d);
		end
	end

	// Stage 3: clamp the interpolation span and scale the rainbow numerators.
	logic signed [15:0] den_d, num_d;

	always_comb begin
		den_d = r_s2 - l_s2;
		num_d = mid_s2 - l_s2;
		if (den_d <= 16'sd0) den_d = 16'sd1;
		if (num_d < 16'sd0) num_d = 16'sd0;
		if (num_d >= den_d) num_d = den_d - 16'sd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ack_s3 <= ack_s2;
			blend_s3 <= blend_s2;
			rb_s3 <= rb_s2;
			res_s3 <= res_s2;
			lc_s3 <= lc_s2;
			rc_s3 <= rc_s2;
			den_s3 <= den_d[13:0];
			num_s3 <= num_d[13:0];
			sec_s3 <= sec_s2;
			ymd_s3 <= 17'((25'(amd_s2) * 25'd255) >> 8);
			ylo_s3 <= 17'((25'(alo_s2) * 25'd255) >> 8);
		end
	end

	// Stage 4: finish the rainbow color. Stages 4 to 11: fraction divider.
	logic [7:0] md_d, lo_d;
	logic [CW-1:0] rb_d;
	logic [13:0] rem_n [NDS];
	logic [FW-1:0] q_n [NDS];

	always_comb begin
		md_d = 8'((34'(ymd_s3) * 34'(ccg_pkg::RECIP_375)) >> ccg_pkg::RECIP_SHIFT);
		lo_d = 8'((34'(ylo_s3) * 34'(ccg_pkg::RECIP_375)) >> ccg_pkg::RECIP_SHIFT);
		case (sec_s3)
			3'd0: rb_d = {8'hFF, md_d, lo_d};
			3'd1: rb_d = {md_d, 8'hFF, lo_d};
			3'd2: rb_d = {lo_d, 8'hFF, md_d};
			3'd3: rb_d = {lo_d, md_d, 8'hFF};
			3'd4: rb_d = {md_d, lo_d, 8'hFF};
			default: rb_d = {8'hFF, lo_d, md_d};
		endcase
	end

	always_comb begin
		logic [14:0] r2;
		logic [13:0] rr;
		logic [13:0] dd;
		logic [FW-1:0] qq;
		for (int j = 0; j < NDS; j++) begin
			rr = (j == 0) ? num_s3 : rem_s4[(j == 0) ? 0 : j - 1];
			dd = (j == 0) ? den_s3 : den_s4[(j == 0) ? 0 : j - 1];
			qq = (j == 0) ? '0 : q_s4[(j == 0) ? 0 : j - 1];
			for (int k = 0; k < ccg_pkg::DIV_PER_STAGE; k++) begin
				r2 = {rr, 1'b0};
				if (r2 >= {1'b0, dd}) begin
					r2 = r2 - {1'b0, dd};
					qq = {qq[FW-2:0], 1'b1};
				end else begin
					qq = {qq[FW-2:0], 1'b0};
				end
				rr = r2[13:0];
			end
			rem_n[j] = rr;
			q_n[j] = qq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NDS; j++) v_s4[j] <= 1'b0;
		end else if (adv) begin
			v_s4[0] <= v_s3;
			for (int j = 1; j < NDS; j++) v_s4[j] <= v_s4[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ack_s4[0] <= ack_s3;
			blend_s4[0] <= blend_s3;
			res_s4[0] <= rb_s3 ? rb_d : res_s3;
			lc_s4[0] <= lc_s3;
			rc_s4[0] <= rc_s3;
			den_s4[0] <= den_s3;
			for (int j = 1; j < NDS; j++) begin
				ack_s4[j] <= ack_s4[j-1];
				blend_s4[j] <= blend_s4[j-1];
				res_s4[j] <= res_s4[j-1];
				lc_s4[j] <= lc_s4[j-1];
				rc_s4[j] <= rc_s4[j-1];
				den_s4[j] <= den_s4[j-1];
			end
			for (int j = 0; j < NDS; j++) begin
				rem_s4[j] <= rem_n[j];
				q_s4[j] <= q_n[j];
			end
		end
	end

	// Stage 12: channel weights. Stage 13: channel sums and output.
	logic [16:0] wl;
	logic [CW-1:0] blend_color;

	always_comb begin
		wl = 17'h10000 - 17'(q_s4[NDS-1]);
		for (int c = 0; c < 3; c++) begin
			blend_color[c*8 +: 8] = 8'((26'(pl_s12[c]) + 26'(pr_s12[c])) >> FW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (adv) begin
			v_s12 <= v_s4[NDS-1];
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ack_s12 <= ack_s4[NDS-1];
			blend_s12 <= blend_s4[NDS-1];
			res_s12 <= res_s4[NDS-1];
			for (int c = 0; c < 3; c++) begin
				pl_s12[c] <= 25'(lc_s4[NDS-1][c*8 +: 8]) * 25'(wl);
				pr_s12[c] <= 24'(rc_s4[NDS-1][c*8 +: 8]) * 24'(q_s4[NDS-1]);
			end
			ack_s13 <= ack_s12;
			color_s13 <= blend_s12 ? blend_color : res_s12;
		end
	end

	a_ack_zero_color: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.write_ack |-> rsp.color == '0)
		else $error("keypoint write acknowledged with a nonzero color");

	a_span_ok: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && blend_s3 |-> (den_s3 != '0) && (num_s3 < den_s3))
		else $error("interpolation span out of range");

	a_rainbow_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rb_s3 |-> ylo_s3 <= ymd_s3)
		else $error("rainbow minimum channel above middle channel");

endmodule
`default_nettype wire

FILE: sim/chroma_color_generator_tb.sv
// Self-checking testbench for the chroma color generator: directed and random requests.
`timescale 1ns / 1ps
module chroma_color_generator_tb;

	typedef struct packed {
		logic [ccg_pkg::REQ_W-1:0] req_type;
		logic [ccg_pkg::COLOR_W-1:0] default_color;
		logic [ccg_pkg::PHASE_W-1:0] phase;
		logic [ccg_pkg::PCT_W-1:0] percentage;
		logic [ccg_pkg::PROG_W-1:0] progress;
		logic [ccg_pkg::KIDX_W-1:0] key_index;
		logic [ccg_pkg::KPOS_W-1:0] key_position;
		logic [ccg_pkg::COLOR_W-1:0] key_color;
	} request_t;

	typedef struct packed {
		logic [ccg_pkg::COLOR_W-1:0] color;
		logic write_ack;
	} answer_t;

	localparam int KEYS = 8;
	localparam int LATENCY = 13;
	localparam int STALL_LIMIT = 5000;
	localparam logic [ccg_pkg::REQ_W-1:0] REQ_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we = 1'b0;
	logic [ccg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ccg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	ccg_req_if req_ch ();
	ccg_rsp_if rsp_ch ();

	chroma_color_generator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the block's configuration and keypoint tables.
	logic en_q;
	logic [2:0] mode_q;
	logic [ccg_pkg::COLOR_W-1:0] static_q;
	logic [6:0] sat_q;
	logic best_q;
	logic [ccg_pkg::CNT_W-1:0] hue_cnt_q, prog_cnt_q;
	logic [8:0] hue_pos [KEYS];
	logic [ccg_pkg::COLOR_W-1:0] hue_col [KEYS];
	logic [6:0] prog_pos [KEYS];
	logic [ccg_pkg::COLOR_W-1:0] prog_col [KEYS];

	request_t pending [$];
	answer_t expected_answers [$];
	bit failed = 0;
	bit no_idle = 0;
	int quiet_cycles = 0;

	function automatic logic [ccg_pkg::COLOR_W-1:0] mix(longint mid, longint lpos,
		logic [ccg_pkg::COLOR_W-1:0] lc, longint rpos, logic [ccg_pkg::COLOR_W-1:0] rc);
		longint den, num, frac, v;
		logic [ccg_pkg::COLOR_W-1:0] res;
		den = rpos - lpos;
		num = mid - lpos;
		if (den <= 0) den = 1;
		if (num < 0) num = 0;
		if (num >= den) num = den - 1;
		frac = (num * 65536) / den;
		for (int s = 0; s < 24; s += 8) begin
			v = (longint'(lc[s+:8]) * (65536 - frac) + longint'(rc[s+:8]) * frac) >>> 16;
			res[s+:8] = v[7:0];
		end
		return res;
	endfunction

	function automatic logic [ccg_pkg::COLOR_W-1:0] rainbow_color(
		logic [ccg_pkg::PHASE_W-1:0] ph);
		int h, sec, f, s, lo, md, t;
		logic [7:0] r, g, b;
		h = ph % ccg_pkg::HUE_FULL;
		sec = h / ccg_pkg::HUE_SECTOR;
		f = h % ccg_pkg::HUE_SECTOR;
		s = sat_q > ccg_pkg::SAT_MAX ? ccg_pkg::SAT_MAX : int'(sat_q);
		lo = (255 * (100 - s) * 960) / 96000;
		t = sec[0] ? 960 - f : f;
		md = (255 * ((100 - s) * 960 + s * t)) / 96000;
		case (sec)
			0: begin r = 8'd255; g = 8'(md); b = 8'(lo); end
			1: begin r = 8'(md); g = 8'd255; b = 8'(lo); end
			2: begin r = 8'(lo); g = 8'd255; b = 8'(md); end
			3: begin r = 8'(lo); g = 8'(md); b = 8'd255; end
			4: begin r = 8'(md); g = 8'(lo); b = 8'd255; end
			default: begin r = 8'd255; g = 8'(lo); b = 8'(md); end
		endcase
		return {r, g, b};
	endfunction

	function automatic logic [ccg_pkg::COLOR_W-1:0] hue_color(
		logic [ccg_pkg::PHASE_W-1:0] ph);
		int n;
		longint mid, rp;
		n = hue_cnt_q > KEYS ? KEYS : int'(hue_cnt_q);
		mid = ph % ccg_pkg::HUE_FULL;
		for (int i = 0; i < n; i++) begin
			rp = longint'(hue_pos[i]) * 16;
			if (rp > mid) begin
				if (i == 0)
					return mix(mid, (longint'(hue_pos[n-1]) - 360) * 16, hue_col[n-1],
						rp, hue_col[0]);
				return mix(mid, longint'(hue_pos[i-1]) * 16, hue_col[i-1], rp, hue_col[i]);
			end
		end
		return mix(mid, longint'(hue_pos[n-1]) * 16, hue_col[n-1],
			(longint'(hue_pos[0]) + 360) * 16, hue_col[0]);
	endfunction

	function automatic logic [ccg_pkg::COLOR_W-1:0] progress_color(longint mid);
		int n;
		longint rp;
		n = prog_cnt_q > KEYS ? KEYS : int'(prog_cnt_q);
		for (int i = 0; i < n; i++) begin
			rp = longint'(prog_pos[i]) * 128;
			if (rp > mid) begin
				if (i == 0) return prog_col[0];
				return mix(mid, longint'(prog_pos[i-1]) * 128, prog_col[i-1], rp, prog_col[i]);
			end
		end
		return prog_col[n-1];
	endfunction

	function automatic answer_t predict_answer(request_t r);
		answer_t a;
		a = '0;
		if (r.req_type == ccg_pkg::REQ_COMPUTE) begin
			a.color = r.default_color;
			if (en_q) begin
				case (mode_q)
					ccg_pkg::MODE_STATIC: a.color = static_q;
					ccg_pkg::MODE_RAINBOW: a.color = rainbow_color(r.phase);
					ccg_pkg::MODE_HUE_GRAD: if (hue_cnt_q != 0) a.color = hue_color(r.phase);
					ccg_pkg::MODE_PROG_GRAD: begin
						if (prog_cnt_q != 0)
							a.color = progress_color(best_q ? longint'(r.progress) * 128
								: longint'(r.percentage));
					end
					default: ;
				endcase
			end
		end else if (r.req_type == ccg_pkg::REQ_HUE_KEY) begin
			a.write_ack = 1'b1;
			hue_pos[r.key_index] = (r.key_position > ccg_pkg::HUE_POS_MAX) ?
				9'(ccg_pkg::HUE_POS_MAX) : r.key_position;
			hue_col[r.key_index] = r.key_color;
		end else if (r.req_type == ccg_pkg::REQ_PROG_KEY) begin
			a.write_ack = 1'b1;
			prog_pos[r.key_index] = (r.key_position > ccg_pkg::PROG_POS_MAX) ?
				7'(ccg_pkg::PROG_POS_MAX) : r.key_position[6:0];
			prog_col[r.key_index] = r.key_color;
		end
		return a;
	endfunction

	// Driver: predicts each item when it is accepted and holds a waiting item.
	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			expected_answers.push_back(predict_answer(pending.pop_front()));
		end
		if (req_ch.valid && !req_ch.ready) begin
			req_ch.valid <= 1'b1;
		end else if (arst_n && pending.size() > 0 && (no_idle || $urandom_range(99) >= 14)) begin
			req_ch.valid <= 1'b1;
			{req_ch.req_type, req_ch.default_color, req_ch.phase, req_ch.percentage,
				req_ch.progress, req_ch.key_index, req_ch.key_position,
				req_ch.key_color} <= pending[0];
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// Monitor: compares each result with the oldest expectation.
	always @(posedge clk) begin
		answer_t e;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_answers.size() == 0) begin
				$error("unexpected item: color %06h write_ack %0b", rsp_ch.color,
					rsp_ch.write_ack);
				failed = 1;
			end else begin
				e = expected_answers.pop_front();
				if (rsp_ch.color !== e.color) begin
					$error("color: expected %06h actual %06h", e.color, rsp_ch.color);
					failed = 1;
				end
				if (rsp_ch.write_ack !== e.write_ack) begin
					$error("write_ack: expected %0b actual %0b", e.write_ack, rsp_ch.write_ack);
					failed = 1;
				end
			end
		end
		rsp_ch.ready <= no_idle || $urandom_range(99) >= 14;
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL chroma_color_generator");
			$finish;
		end
	end

	task automatic write_reg(input logic [ccg_pkg::CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 24'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ccg_pkg::CFG_ENABLE: en_q = val[0];
			ccg_pkg::CFG_MODE: mode_q = val[2:0];
			ccg_pkg::CFG_STATIC_COLOR: static_q = val[23:0];
			ccg_pkg::CFG_SATURATION: sat_q = val[6:0];
			ccg_pkg::CFG_USE_BEST: best_q = val[0];
			ccg_pkg::CFG_GRADIENT_COUNT: hue_cnt_q = val[3:0];
			ccg_pkg::CFG_PROGRESS_COUNT: prog_cnt_q = val[3:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending.size() > 0 || expected_answers.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic request_t compute_item();
		request_t r;
		r = '0;
		r.req_type = ccg_pkg::REQ_COMPUTE;
		r.default_color = 24'($urandom);
		r.phase = 16'($urandom);
		r.percentage = 14'($urandom_range(12800));
		r.progress = 7'($urandom_range(100));
		r.key_index = 3'($urandom);
		r.key_position = 9'($urandom);
		r.key_color = 24'($urandom);
		return r;
	endfunction

	function automatic request_t key_item(logic [ccg_pkg::REQ_W-1:0] kind, int idx, int pos,
		logic [ccg_pkg::COLOR_W-1:0] col);
		request_t r;
		r = compute_item();
		r.req_type = kind;
		r.key_index = 3'(idx);
		r.key_position = 9'(pos);
		r.key_color = col;
		return r;
	endfunction

	// Loads both tables in non-decreasing position order, with random colors.
	task automatic load_tables();
		int hp, pp;
		hp = $urandom_range(20);
		pp = $urandom_range(10);
		for (int i = 0; i < KEYS; i++) begin
			pending.push_back(key_item(ccg_pkg::REQ_HUE_KEY, i, hp, 24'($urandom)));
			pending.push_back(key_item(ccg_pkg::REQ_PROG_KEY, i, pp, 24'($urandom)));
			hp += $urandom_range(50);
			pp += $urandom_range(16);
		end
	endtask

	initial begin
		request_t r;
		arst_n <= 1'b0;
		en_q = 0; mode_q = 0; static_q = 24'hFFFFFF; sat_q = 100; best_q = 0;
		hue_cnt_q = 0; prog_cnt_q = 0;
		req_ch.valid = 1'b0;
		{req_ch.req_type, req_ch.default_color, req_ch.phase, req_ch.percentage,
			req_ch.progress, req_ch.key_index, req_ch.key_position, req_ch.key_color} = '0;
		rsp_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: disabled block, key writes with saturating positions, odd requests.
		pending.push_back(compute_item());
		pending.push_back(key_item(ccg_pkg::REQ_HUE_KEY, 0, 0, 24'h000000));
		pending.push_back(key_item(ccg_pkg::REQ_HUE_KEY, 1, 120, 24'hFF0000));
		pending.push_back(key_item(ccg_pkg::REQ_HUE_KEY, 2, 511, 24'hFFFFFF));
		pending.push_back(key_item(ccg_pkg::REQ_PROG_KEY, 0, 0, 24'h00FF00));
		pending.push_back(key_item(ccg_pkg::REQ_PROG_KEY, 1, 50, 24'h0000FF));
		pending.push_back(key_item(ccg_pkg::REQ_PROG_KEY, 2, 511, 24'hFFFFFF));
		r = compute_item();
		r.req_type = REQ_NONE;
		pending.push_back(r);
		drain();
		write_reg(ccg_pkg::CFG_ENABLE, 1);
		for (int m = 0; m < 8; m++) begin
			write_reg(ccg_pkg::CFG_MODE, m);
			write_reg(ccg_pkg::CFG_GRADIENT_COUNT, 0);
			write_reg(ccg_pkg::CFG_PROGRESS_COUNT, 0);
			pending.push_back(compute_item());
			drain();
			write_reg(ccg_pkg::CFG_GRADIENT_COUNT, 3);
			write_reg(ccg_pkg::CFG_PROGRESS_COUNT, 3);
			r = compute_item();
			r.phase = 16'hFFFF;
			r.percentage = 14'd12800;
			pending.push_back(r);
			r.phase = '0;
			r.percentage = '0;
			pending.push_back(r);
			drain();
		end

		// Random phases with the whole table loaded; some sets go without idling.
		for (int ph = 0; ph < 24; ph++) begin
			no_idle = (ph == 5 || ph == 6);
			load_tables();
			drain();
			write_reg(ccg_pkg::CFG_ENABLE, $urandom_range(7) != 0);
			write_reg(ccg_pkg::CFG_MODE, ph < 4 ? ph % 8 : $urandom_range(7));
			write_reg(ccg_pkg::CFG_STATIC_COLOR, ph == 0 ? 0 : $urandom & 24'hFFFFFF);
			write_reg(ccg_pkg::CFG_SATURATION, ph == 1 ? 0 : ph == 2 ? 100 : ph == 3 ? 127
				: $urandom_range(127));
			write_reg(ccg_pkg::CFG_USE_BEST, $urandom_range(1));
			write_reg(ccg_pkg::CFG_GRADIENT_COUNT, ph == 4 ? 15 : $urandom_range(1, KEYS));
			write_reg(ccg_pkg::CFG_PROGRESS_COUNT, ph == 4 ? 15 : $urandom_range(1, KEYS));
			for (int k = 0; k < 46; k++) begin
				if ($urandom_range(19) == 0)
					pending.push_back(key_item(2'($urandom_range(3)), $urandom_range(7),
						$urandom_range(511), 24'($urandom)));
				else
					pending.push_back(compute_item());
			end
			drain();
		end
		no_idle = 0;

		if (!failed)
			$display("PASS chroma_color_generator");
		else
			$display("FAIL chroma_color_generator");
		$finish;
	end
endmodule
